### rtl/core/voxel_light_max_mip_pyramid_top_assert.svh
// Assertion macros for the voxel light mip pyramid top level.
`ifndef VOXEL_LIGHT_MAX_MIP_PYRAMID_TOP_ASSERT_SVH
`define VOXEL_LIGHT_MAX_MIP_PYRAMID_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define VLMP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vlmp: implication check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define VLMP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vlmp: next-cycle check failed");

`endif

### rtl/core/vlmp_pkg.sv
// Shared types, constants and helper functions for the voxel light mip pyramid.
`default_nettype none
package vlmp_pkg;

  localparam int EDGE_DEF      = 32;
  localparam int TOP_LEVEL_DEF = 5;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // word index of the configuration registers
  localparam logic REG_DEFAULT_LIGHT = 1'b0;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC0,
    ST_MAC1,
    ST_MAC2,
    ST_LOOKUP,
    ST_EVAL,
    ST_POOL,
    ST_POOL_END,
    ST_DONE
  } vlmp_state_t;

  // offset of a level inside the packed mip store (levels 1 and up)
  function automatic int level_base(int edge_n, int lvl);
    int acc;
    int s;
    acc = 0;
    for (int k = 1; k < 8; k++) begin
      s = edge_n >> k;
      if (k < lvl) acc = acc + s * s * s;
    end
    return acc;
  endfunction

  // index distance of child d from the even corner of its 2x2x2 group
  function automatic int child_off(int edge_n, int lvl, int d);
    int cs;
    cs = edge_n >> lvl;
    return (d & 1) + ((d >> 1) & 1) * cs + ((d >> 2) & 1) * cs * cs;
  endfunction

  // per-nibble maximum of two packed light bytes
  function automatic logic [7:0] nib_max(logic [7:0] a, logic [7:0] b);
    logic [3:0] hi;
    logic [3:0] lo;
    hi = (a[7:4] > b[7:4]) ? a[7:4] : b[7:4];
    lo = (a[3:0] > b[3:0]) ? a[3:0] : b[3:0];
    return {hi, lo};
  endfunction

endpackage
`default_nettype wire

### rtl/core/voxel_light_max_mip_pyramid_top.sv
// Top level: voxel light store with a max-pooled mip pyramid and its sequencer.
`default_nettype none
`include "voxel_light_max_mip_pyramid_top_assert.svh"

// Voxel light store with a per-nibble max mip pyramid. After reset the block
// zeroes both single-port stores, one entry per cycle, over the EDGE^3 base entries
// (32768 at EDGE 32); in_ready stays low meanwhile, config writes still work.
// Items are handled one at a time by one shared multiply-add unit that forms
// every store index in the states MAC0, MAC1 and MAC2. A read then looks up
// its entry and goes back to ready through DONE. A write does the same and, per
// mip level it recomputes, does eight child reads, the index build, and the parent
// read and write on the same memory port, for up to TOP_LEVEL levels. Reads or
// writes outside the addressed volume skip the index build and go to DONE. A finished result
// sits in the output register while the next transaction is accepted.
module voxel_light_max_mip_pyramid_top #(
  parameter int EDGE      = vlmp_pkg::EDGE_DEF,
  parameter int TOP_LEVEL = vlmp_pkg::TOP_LEVEL_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_cmd,
  input  wire logic [4:0]  in_x_coord,
  input  wire logic [4:0]  in_y_coord,
  input  wire logic [4:0]  in_z_coord,
  input  wire logic [2:0]  in_mip_level,
  input  wire logic [7:0]  in_light_value,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_read_light,
  output logic [5:0]       out_changed_mask,
  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int BASE_DEPTH = EDGE * EDGE * EDGE;
  localparam int MIP_DEPTH  = BASE_DEPTH / 7 + TOP_LEVEL + 1;
  localparam int ACC_W      = $clog2(BASE_DEPTH);
  localparam int MIP_AW     = $clog2(MIP_DEPTH);
  localparam int EW         = $clog2(EDGE + 1);
  localparam int LVL_W      = $clog2(TOP_LEVEL + 1);

  // ---------------------------------------------------------------------------
  // constant tables per level
  logic [EW-1:0]    edge_tab  [TOP_LEVEL+1];
  logic [ACC_W-1:0] lbase_tab [TOP_LEVEL+1];
  logic [ACC_W-1:0] off_tab   [TOP_LEVEL+1][8];

  for (genvar g = 0; g <= TOP_LEVEL; g++) begin : g_lvl
    assign edge_tab[g]  = EW'(EDGE >> g);
    assign lbase_tab[g] = ACC_W'(vlmp_pkg::level_base(EDGE, g));
    for (genvar d = 0; d < 8; d++) begin : g_off
      assign off_tab[g][d] = ACC_W'(vlmp_pkg::child_off(EDGE, g, d));
    end
  end

  // ---------------------------------------------------------------------------
  // registers
  vlmp_pkg::vlmp_state_t st_r, st_nxt;

  logic [ACC_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [7:0]       dflt_r, dflt_nxt;
  logic             cmd_r, cmd_nxt;
  logic [4:0]       x_r, x_nxt;
  logic [4:0]       y_r, y_nxt;
  logic [4:0]       z_r, z_nxt;
  logic [LVL_W-1:0] lvl_r, lvl_nxt;
  logic [7:0]       val_r, val_nxt;
  logic [5:0]       mask_r, mask_nxt;
  logic [7:0]       rd_r, rd_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [ACC_W-1:0] ebase_r, ebase_nxt;
  logic [2:0]       d_r, d_nxt;
  logic [7:0]       mx_r, mx_nxt;
  logic             rvld_r, rvld_nxt;
  logic             qsel_r, qsel_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_light_r, out_light_nxt;
  logic [5:0]       out_mask_r, out_mask_nxt;

  // memories
  logic [7:0]        base_mem [BASE_DEPTH];
  logic [7:0]        mip_mem  [MIP_DEPTH];
  logic [7:0]        base_q_r;
  logic [7:0]        mip_q_r;
  logic              base_we, base_re;
  logic [ACC_W-1:0]  base_addr;
  logic [7:0]        base_wdata;
  logic              mip_we, mip_re;
  logic [MIP_AW-1:0] mip_addr;
  logic [7:0]        mip_wdata;

  // shared multiply-add unit
  logic [ACC_W-1:0]    mac_a;
  logic [EW-1:0]       mac_b;
  logic [ACC_W-1:0]    mac_c;
  logic [ACC_W+EW-1:0] mac_prod;
  logic [ACC_W-1:0]    mac_res;

  // ---------------------------------------------------------------------------
  // derived control terms
  logic             in_fire;
  logic             cfg_wr;
  logic [LVL_W-1:0] rd_lvl;
  logic             rd_oor;
  logic             wr_oor;
  logic [LVL_W-1:0] clvl;
  logic [LVL_W-1:0] lvl_up;
  logic             at_top;
  logic             par_oor;
  logic [7:0]       mem_q;
  logic             q_eq;
  logic [ACC_W-1:0] self_addr;
  logic [ACC_W-1:0] child_addr;
  logic [5:0]       cx, cy, cz;
  logic             child_ok;
  logic [4:0]       mx_c, my_c, mz_c;
  logic [7:0]       pool_acc;
  logic             clr_last;
  logic             out_slot;

  assign in_fire  = in_valid && in_ready;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign rd_lvl   = (32'(in_mip_level) > TOP_LEVEL) ? LVL_W'(TOP_LEVEL)
                                                     : in_mip_level[LVL_W-1:0];
  assign rd_oor   = (32'(in_x_coord) >= 32'(edge_tab[rd_lvl])) ||
                    (32'(in_y_coord) >= 32'(edge_tab[rd_lvl])) ||
                    (32'(in_z_coord) >= 32'(edge_tab[rd_lvl]));
  assign wr_oor   = (32'(in_x_coord) >= EDGE) || (32'(in_y_coord) >= EDGE) ||
                    (32'(in_z_coord) >= EDGE);
  assign clvl     = (lvl_r == '0) ? '0 : lvl_r - LVL_W'(1);
  assign at_top   = (lvl_r == LVL_W'(TOP_LEVEL));
  assign lvl_up   = at_top ? lvl_r : lvl_r + LVL_W'(1);
  assign par_oor  = (32'(x_r >> 1) >= 32'(edge_tab[lvl_up])) ||
                    (32'(y_r >> 1) >= 32'(edge_tab[lvl_up])) ||
                    (32'(z_r >> 1) >= 32'(edge_tab[lvl_up]));
  assign mem_q    = qsel_r ? mip_q_r : base_q_r;
  assign q_eq     = (mem_q == val_r);
  assign self_addr  = (cmd_r == vlmp_pkg::CMD_READ) ? acc_r
                                                     : acc_r + off_tab[lvl_r][{z_r[0], y_r[0], x_r[0]}];
  assign child_addr = ebase_r + off_tab[clvl][d_r];
  assign cx       = {x_r, d_r[0]};
  assign cy       = {y_r, d_r[1]};
  assign cz       = {z_r, d_r[2]};
  assign child_ok = (32'(cx) < 32'(edge_tab[clvl])) && (32'(cy) < 32'(edge_tab[clvl])) &&
                    (32'(cz) < 32'(edge_tab[clvl]));
  // writes index the even corner; the self offset is added on lookup
  assign mx_c     = (cmd_r == vlmp_pkg::CMD_READ) ? x_r : {x_r[4:1], 1'b0};
  assign my_c     = (cmd_r == vlmp_pkg::CMD_READ) ? y_r : {y_r[4:1], 1'b0};
  assign mz_c     = (cmd_r == vlmp_pkg::CMD_READ) ? z_r : {z_r[4:1], 1'b0};
  assign pool_acc = rvld_r ? vlmp_pkg::nib_max(mx_r, mem_q) : mx_r;
  assign clr_last = (32'(clr_cnt_r) == BASE_DEPTH - 1);
  assign out_slot = !out_valid_r || out_ready;

  assign mac_prod = mac_a * mac_b;
  assign mac_res  = mac_prod[ACC_W-1:0] + mac_c;

  // ---------------------------------------------------------------------------
  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      vlmp_pkg::ST_CLEAR: begin
        if (clr_last) st_nxt = vlmp_pkg::ST_IDLE;
      end
      vlmp_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_cmd == vlmp_pkg::CMD_READ) begin
            st_nxt = rd_oor ? vlmp_pkg::ST_DONE : vlmp_pkg::ST_MAC0;
          end else begin
            st_nxt = wr_oor ? vlmp_pkg::ST_DONE : vlmp_pkg::ST_MAC0;
          end
        end
      end
      vlmp_pkg::ST_MAC0:   st_nxt = vlmp_pkg::ST_MAC1;
      vlmp_pkg::ST_MAC1:   st_nxt = vlmp_pkg::ST_MAC2;
      vlmp_pkg::ST_MAC2:   st_nxt = vlmp_pkg::ST_LOOKUP;
      vlmp_pkg::ST_LOOKUP: st_nxt = vlmp_pkg::ST_EVAL;
      vlmp_pkg::ST_EVAL: begin
        if (cmd_r == vlmp_pkg::CMD_READ || q_eq || at_top || par_oor) begin
          st_nxt = vlmp_pkg::ST_DONE;
        end else begin
          st_nxt = vlmp_pkg::ST_POOL;
        end
      end
      vlmp_pkg::ST_POOL: begin
        if (d_r == 3'd7) st_nxt = vlmp_pkg::ST_POOL_END;
      end
      vlmp_pkg::ST_POOL_END: st_nxt = vlmp_pkg::ST_MAC0;
      vlmp_pkg::ST_DONE: begin
        if (out_slot) st_nxt = vlmp_pkg::ST_IDLE;
      end
      default: st_nxt = vlmp_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // state outputs: handshake, memory port controls, multiply-add operands
  always_comb begin
    in_ready   = 1'b0;
    base_we    = 1'b0;
    base_re    = 1'b0;
    base_addr  = self_addr;
    base_wdata = val_r;
    mip_we     = 1'b0;
    mip_re     = 1'b0;
    mip_addr   = self_addr[MIP_AW-1:0];
    mip_wdata  = val_r;
    mac_a      = acc_r;
    mac_b      = edge_tab[lvl_r];
    mac_c      = ACC_W'(mx_c);
    case (st_r)
      vlmp_pkg::ST_CLEAR: begin
        base_we    = 1'b1;
        base_addr  = clr_cnt_r;
        base_wdata = 8'd0;
        mip_we     = (32'(clr_cnt_r) < MIP_DEPTH);
        mip_addr   = clr_cnt_r[MIP_AW-1:0];
        mip_wdata  = 8'd0;
      end
      vlmp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      vlmp_pkg::ST_MAC0: begin
        mac_a = ACC_W'(mz_c);
        mac_c = ACC_W'(my_c);
      end
      vlmp_pkg::ST_MAC1: begin
        mac_c = ACC_W'(mx_c);
      end
      vlmp_pkg::ST_MAC2: begin
        mac_b = EW'(1);
        mac_c = lbase_tab[lvl_r];
      end
      vlmp_pkg::ST_LOOKUP: begin
        if (lvl_r == '0) base_re = 1'b1;
        else mip_re = 1'b1;
      end
      vlmp_pkg::ST_EVAL: begin
        if (cmd_r == vlmp_pkg::CMD_WRITE && !q_eq) begin
          if (lvl_r == '0) base_we = 1'b1;
          else mip_we = 1'b1;
        end
      end
      vlmp_pkg::ST_POOL: begin
        base_addr = child_addr;
        mip_addr  = child_addr[MIP_AW-1:0];
        if (child_ok) begin
          if (clvl == '0) base_re = 1'b1;
          else mip_re = 1'b1;
        end
      end
      vlmp_pkg::ST_POOL_END: begin
      end
      vlmp_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // datapath next values
  always_comb begin
    clr_cnt_nxt   = clr_cnt_r;
    dflt_nxt      = dflt_r;
    cmd_nxt       = cmd_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    z_nxt         = z_r;
    lvl_nxt       = lvl_r;
    val_nxt       = val_r;
    mask_nxt      = mask_r;
    rd_nxt        = rd_r;
    acc_nxt       = acc_r;
    ebase_nxt     = ebase_r;
    d_nxt         = d_r;
    mx_nxt        = mx_r;
    rvld_nxt      = 1'b0;
    qsel_nxt      = mip_re ? 1'b1 : (base_re ? 1'b0 : qsel_r);
    out_valid_nxt = out_valid_r && !out_ready;
    out_light_nxt = out_light_r;
    out_mask_nxt  = out_mask_r;

    if (cfg_wr && cfg_paddr[2] == vlmp_pkg::REG_DEFAULT_LIGHT) dflt_nxt = cfg_pwdata[7:0];

    case (st_r)
      vlmp_pkg::ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + ACC_W'(1);
      end
      vlmp_pkg::ST_IDLE: begin
        if (in_fire) begin
          cmd_nxt  = in_cmd;
          x_nxt    = in_x_coord;
          y_nxt    = in_y_coord;
          z_nxt    = in_z_coord;
          val_nxt  = in_light_value;
          mask_nxt = 6'd0;
          rd_nxt   = 8'd0;
          if (in_cmd == vlmp_pkg::CMD_READ) begin
            lvl_nxt = rd_lvl;
            if (rd_oor) rd_nxt = dflt_r;
          end else begin
            lvl_nxt = '0;
          end
        end
      end
      vlmp_pkg::ST_MAC0, vlmp_pkg::ST_MAC1, vlmp_pkg::ST_MAC2: begin
        acc_nxt = mac_res;
      end
      vlmp_pkg::ST_LOOKUP: begin
      end
      vlmp_pkg::ST_EVAL: begin
        if (cmd_r == vlmp_pkg::CMD_READ) begin
          rd_nxt = mem_q;
        end else if (!q_eq) begin
          mask_nxt  = mask_r | (6'd1 << lvl_r);
          ebase_nxt = acc_r;
          d_nxt     = 3'd0;
          mx_nxt    = 8'd0;
          if (!at_top) begin
            x_nxt   = x_r >> 1;
            y_nxt   = y_r >> 1;
            z_nxt   = z_r >> 1;
            lvl_nxt = lvl_up;
          end
        end
      end
      vlmp_pkg::ST_POOL: begin
        mx_nxt   = pool_acc;
        rvld_nxt = child_ok;
        d_nxt    = d_r + 3'd1;
      end
      vlmp_pkg::ST_POOL_END: begin
        val_nxt = pool_acc;
      end
      vlmp_pkg::ST_DONE: begin
        if (out_slot) begin
          out_valid_nxt = 1'b1;
          out_light_nxt = rd_r;
          out_mask_nxt  = mask_r;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= vlmp_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      dflt_r      <= 8'd0;
      rvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      dflt_r      <= dflt_nxt;
      rvld_r      <= rvld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    z_r         <= z_nxt;
    lvl_r       <= lvl_nxt;
    val_r       <= val_nxt;
    mask_r      <= mask_nxt;
    rd_r        <= rd_nxt;
    acc_r       <= acc_nxt;
    ebase_r     <= ebase_nxt;
    d_r         <= d_nxt;
    mx_r        <= mx_nxt;
    qsel_r      <= qsel_nxt;
    out_light_r <= out_light_nxt;
    out_mask_r  <= out_mask_nxt;
  end

  // single-port stores, registered read data
  always_ff @(posedge clk) begin
    if (base_we) base_mem[base_addr] <= base_wdata;
    if (base_re) base_q_r <= base_mem[base_addr];
  end

  always_ff @(posedge clk) begin
    if (mip_we) mip_mem[mip_addr] <= mip_wdata;
    if (mip_re) mip_q_r <= mip_mem[mip_addr];
  end

  // ---------------------------------------------------------------------------
  // ports
  assign out_valid        = out_valid_r;
  assign out_read_light   = out_light_r;
  assign out_changed_mask = out_mask_r;
  assign cfg_pready       = 1'b1;
  assign cfg_prdata       = (cfg_paddr[2] == vlmp_pkg::REG_DEFAULT_LIGHT) ? {24'd0, dflt_r}
                                                                         : 32'd0;

  // ---------------------------------------------------------------------------
  // assertions
  `VLMP_ASSERT_IMP(a_mask_contiguous, out_valid, (out_changed_mask & 6'(out_changed_mask + 6'd1)) == 6'd0)
  `VLMP_ASSERT_IMP(a_read_has_no_mask, out_valid && out_read_light != 8'd0, out_changed_mask == 6'd0)
  `VLMP_ASSERT_IMP(a_base_single_port, base_we, !base_re)
  `VLMP_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule
`default_nettype wire

### verif/voxel_light_max_mip_pyramid_tb.sv
// Self-checking testbench for the voxel light mip pyramid top level.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE = vlmp_pkg::EDGE_DEF;
  localparam int TOP  = vlmp_pkg::TOP_LEVEL_DEF;
  localparam int VOXELS = SIDE * SIDE * SIDE;

  typedef struct packed {
    logic       cmd;
    logic [4:0] x;
    logic [4:0] y;
    logic [4:0] z;
    logic [2:0] lvl;
    logic [7:0] light;
  } vox_cmd_t;

  typedef struct packed {
    logic [7:0] read_light;
    logic [5:0] changed_mask;
  } vox_resp_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_cmd;
  logic [4:0]  in_x_coord;
  logic [4:0]  in_y_coord;
  logic [4:0]  in_z_coord;
  logic [2:0]  in_mip_level;
  logic [7:0]  in_light_value;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_read_light;
  logic [5:0]  out_changed_mask;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  voxel_light_max_mip_pyramid_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_x_coord       (in_x_coord),
    .in_y_coord       (in_y_coord),
    .in_z_coord       (in_z_coord),
    .in_mip_level     (in_mip_level),
    .in_light_value   (in_light_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_light   (out_read_light),
    .out_changed_mask (out_changed_mask),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  // shadow of the light pyramid; level 0 is the base cube
  bit [7:0]   light_pyr [0:TOP][0:VOXELS-1];
  logic [7:0] dflt_light_q;

  vox_cmd_t  cmd_backlog[$];
  vox_resp_t resp_expected[$];
  int        n_issued;
  int        n_answered;
  int        err_count;
  int        in_idle_pct;
  int        out_stall_pct;
  int        gap_left;
  int        stall_left;
  logic      in_took;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1500us;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    err_count++;
  endtask

  function automatic int vox_index(int x, int y, int z, int s);
    return (z * s + y) * s + x;
  endfunction

  // per-nibble max over the eight children of a parent one level up
  function automatic logic [7:0] nibble_pool(int child_lvl, int px, int py, int pz);
    int         cs;
    logic [3:0] sky;
    logic [3:0] blk;
    logic [7:0] v;
    cs  = SIDE >> child_lvl;
    sky = '0;
    blk = '0;
    for (int d = 0; d < 8; d++) begin
      v = light_pyr[child_lvl][vox_index(2 * px + (d & 1), 2 * py + ((d >> 1) & 1),
                                         2 * pz + ((d >> 2) & 1), cs)];
      if (v[7:4] > sky) sky = v[7:4];
      if (v[3:0] > blk) blk = v[3:0];
    end
    return {sky, blk};
  endfunction

  task automatic predict_light(input vox_cmd_t c, output vox_resp_t r);
    int         lv;
    int         s;
    int         px;
    int         py;
    int         pz;
    int         idx;
    logic [7:0] pv;
    r = '0;
    px = c.x;
    py = c.y;
    pz = c.z;
    if (c.cmd == vlmp_pkg::CMD_READ) begin
      lv = (c.lvl > TOP) ? TOP : c.lvl;
      s  = SIDE >> lv;
      if (px >= s || py >= s || pz >= s)
        r.read_light = dflt_light_q;
      else
        r.read_light = light_pyr[lv][vox_index(px, py, pz, s)];
    end else if (px < SIDE && py < SIDE && pz < SIDE) begin
      idx = vox_index(px, py, pz, SIDE);
      if (light_pyr[0][idx] != c.light) begin
        light_pyr[0][idx] = c.light;
        r.changed_mask[0] = 1'b1;
        for (lv = 1; lv <= TOP; lv++) begin
          s  = SIDE >> lv;
          px = px >> 1;
          py = py >> 1;
          pz = pz >> 1;
          if (s == 0 || px >= s || py >= s || pz >= s) break;
          pv  = nibble_pool(lv - 1, px, py, pz);
          idx = vox_index(px, py, pz, s);
          if (light_pyr[lv][idx] == pv) break;
          light_pyr[lv][idx] = pv;
          if (lv < 6) r.changed_mask[lv] = 1'b1;
        end
      end
    end
  endtask

  // input driver
  always @(negedge clk) begin
    vox_cmd_t nxt;
    if (rst_n && (!in_valid || in_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        nxt = cmd_backlog.pop_front();
        in_cmd         <= nxt.cmd;
        in_x_coord     <= nxt.x;
        in_y_coord     <= nxt.y;
        in_z_coord     <= nxt.z;
        in_mip_level   <= nxt.lvl;
        in_light_value <= nxt.light;
        in_valid       <= 1'b1;
        if ($urandom_range(99) < in_idle_pct) gap_left = $urandom_range(1, 9);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result-side backpressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(99) < out_stall_pct) begin
      stall_left = $urandom_range(0, 8);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) in_took <= in_valid && in_ready;

  // monitor: check results, then predict for the transaction accepted here
  always @(posedge clk) begin
    vox_resp_t want;
    vox_cmd_t  seen;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (resp_expected.size() == 0) begin
          report_mismatch($sformatf("result with none pending: light=%h mask=%b",
                                    out_read_light, out_changed_mask));
        end else begin
          want = resp_expected.pop_front();
          if (out_read_light !== want.read_light)
            report_mismatch($sformatf("read_light %h, want %h", out_read_light,
                                      want.read_light));
          if (out_changed_mask !== want.changed_mask)
            report_mismatch($sformatf("changed_mask %b, want %b", out_changed_mask,
                                      want.changed_mask));
          n_answered++;
        end
      end
      if (in_valid && in_ready) begin
        seen = '{in_cmd, in_x_coord, in_y_coord, in_z_coord, in_mip_level, in_light_value};
        predict_light(seen, want);
        resp_expected = {resp_expected, want};
      end
    end
  end

  task automatic queue_item(input logic c, input int x, input int y, input int z,
                            input int lvl, input int light);
    vox_cmd_t t;
    t.cmd   = c;
    t.x     = 5'(x);
    t.y     = 5'(y);
    t.z     = 5'(z);
    t.lvl   = 3'(lvl);
    t.light = 8'(light);
    cmd_backlog = {cmd_backlog, t};
    n_issued++;
  endtask

  function automatic logic [7:0] pick_light();
    case ($urandom_range(0, 6))
      0: return 8'h00;
      1: return 8'h0F;
      2: return 8'hF0;
      3: return 8'hFF;
      4: return {4'($urandom), 4'h0};
      5: return {4'h0, 4'($urandom)};
      default: return 8'($urandom);
    endcase
  endfunction

  // mostly clustered writes and reads around a hot corner so that walks climb
  // high and hit unchanged parents; the rest is fully random
  task automatic queue_random(input int count);
    int hx;
    int hy;
    int hz;
    int x;
    int y;
    int z;
    int lvl;
    int eff;
    for (int i = 0; i < count; i++) begin
      if (i % 32 == 0) begin
        hx = $urandom_range(0, SIDE - 4);
        hy = $urandom_range(0, SIDE - 4);
        hz = $urandom_range(0, SIDE - 4);
      end
      if ($urandom_range(99) < 30) begin
        queue_item(1'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        x = hx + $urandom_range(0, 3);
        y = hy + $urandom_range(0, 3);
        z = hz + $urandom_range(0, 3);
        if ($urandom_range(99) < 55) begin
          queue_item(vlmp_pkg::CMD_WRITE, x, y, z, $urandom, pick_light());
        end else begin
          lvl = $urandom_range(0, 7);
          eff = (lvl > TOP) ? TOP : lvl;
          x = x >> eff;
          y = y >> eff;
          z = z >> eff;
          if ($urandom_range(99) < 10) x = $urandom_range(0, 31);
          queue_item(vlmp_pkg::CMD_READ, x, y, z, lvl, $urandom);
        end
      end
    end
  endtask

  task automatic cfg_write_default(input logic [7:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {vlmp_pkg::REG_DEFAULT_LIGHT, 2'b00};
    cfg_pwdata  <= {24'h0, val};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    dflt_light_q = val;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    // read back
    @(negedge clk);
    cfg_psel    <= 1'b1;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[7:0] !== dflt_light_q)
      report_mismatch($sformatf("default_light reads %h, want %h", cfg_prdata[7:0],
                                dflt_light_q));
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // hold the sender until every queued transaction has its result
  task automatic drain();
    do @(negedge clk); while (n_answered != n_issued);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_cmd         = vlmp_pkg::CMD_WRITE;
    in_x_coord     = '0;
    in_y_coord     = '0;
    in_z_coord     = '0;
    in_mip_level   = '0;
    in_light_value = '0;
    out_ready      = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    in_took        = 1'b0;
    dflt_light_q   = 8'h00;
    n_issued       = 0;
    n_answered     = 0;
    err_count      = 0;
    gap_left       = 0;
    stall_left     = 0;
    in_idle_pct    = 25;
    out_stall_pct  = 25;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    cfg_write_default(8'hC3);
    // directed: pyramid walks, nibble max, unchanged writes, clamps, outside reads
    queue_item(vlmp_pkg::CMD_READ, 0, 0, 0, 0, 8'hFF);
    queue_item(vlmp_pkg::CMD_WRITE, 0, 0, 0, 7, 8'h00);
    queue_item(vlmp_pkg::CMD_WRITE, 0, 0, 0, 0, 8'hF0);
    queue_item(vlmp_pkg::CMD_WRITE, 1, 0, 0, 0, 8'h0F);
    queue_item(vlmp_pkg::CMD_WRITE, 1, 0, 0, 0, 8'h0F);
    queue_item(vlmp_pkg::CMD_WRITE, 1, 1, 1, 0, 8'h33);
    queue_item(vlmp_pkg::CMD_WRITE, 31, 31, 31, 0, 8'hFF);
    queue_item(vlmp_pkg::CMD_READ, 31, 31, 31, 0, 0);
    queue_item(vlmp_pkg::CMD_READ, 15, 15, 15, 1, 0);
    queue_item(vlmp_pkg::CMD_READ, 0, 0, 0, 5, 0);
    queue_item(vlmp_pkg::CMD_READ, 0, 0, 0, 6, 0);
    queue_item(vlmp_pkg::CMD_READ, 0, 0, 0, 7, 0);
    queue_item(vlmp_pkg::CMD_READ, 1, 0, 0, 5, 0);
    queue_item(vlmp_pkg::CMD_READ, 0, 31, 0, 1, 0);
    queue_item(vlmp_pkg::CMD_READ, 1, 1, 1, 4, 0);
    queue_item(vlmp_pkg::CMD_READ, 0, 0, 2, 4, 0);
    queue_item(vlmp_pkg::CMD_READ, 3, 3, 3, 3, 0);
    queue_item(vlmp_pkg::CMD_READ, 4, 0, 0, 3, 0);
    queue_item(vlmp_pkg::CMD_WRITE, 0, 0, 0, 0, 8'h00);
    queue_item(vlmp_pkg::CMD_READ, 0, 0, 0, 1, 0);
    queue_item(vlmp_pkg::CMD_WRITE, 16, 0, 0, 0, 8'hA5);
    queue_item(vlmp_pkg::CMD_WRITE, 0, 16, 0, 0, 8'h5A);
    queue_item(vlmp_pkg::CMD_READ, 31, 31, 31, 7, 0);
    drain();

    cfg_write_default(8'hFF);
    queue_random(300);
    drain();

    in_idle_pct   = 0;
    out_stall_pct = 40;
    cfg_write_default(8'h00);
    queue_random(300);
    drain();

    in_idle_pct   = 40;
    out_stall_pct = 0;
    cfg_write_default(8'($urandom));
    queue_random(300);
    drain();

    // closing stretch runs at full rate on both sides
    in_idle_pct   = 0;
    out_stall_pct = 0;
    cfg_write_default(8'h00);
    queue_random(180);
    drain();

    repeat (100) @(posedge clk);
    if (err_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire
